FILE: rtl/lzfd_pkg.sv
// ----------------------------------------------------------------------------
// lzfd_pkg
// Shared types and constants of the LZ flag-bit decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;

    localparam int WIN_AW   = 12;
    localparam int WIN_DEPTH = 1 << WIN_AW;
    localparam int CNT_W    = 19;
    localparam int LEN_W    = 9;

    localparam logic [CNT_W-1:0] MAX_OUT_RESET = CNT_W'(262144);

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIST     = 2'd1,
        ERR_ZERO_EXT = 2'd2,
        ERR_TRUNC    = 2'd3
    } err_t;

    // one transaction's worth of control, from the parser to the output stage
    typedef struct packed {
        logic              ov;
        logic              copy;
        logic [7:0]        lit;
        logic [WIN_AW-1:0] waddr;
        logic [WIN_AW-1:0] raddr;
        logic              taken;
        logic              done;
        err_t              err;
    } item_t;

endpackage

FILE: rtl/lzfd_hist_ram.sv
// ----------------------------------------------------------------------------
// lzfd_hist_ram
// History window: 4096 x 8 synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module lzfd_hist_ram (
    input  logic                       aclk,
    input  logic                       re,
    input  logic [lzfd_pkg::WIN_AW-1:0] raddr,
    output logic [7:0]                 rdata,
    input  logic                       we,
    input  logic [lzfd_pkg::WIN_AW-1:0] waddr,
    input  logic [7:0]                 wdata
);

    logic [7:0] mem [lzfd_pkg::WIN_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lzfd_parser.sv
// ----------------------------------------------------------------------------
// lzfd_parser
// Token parser and copy sequencer: flag bits, token fields, window pointer,
// output count, limit check and error state. One decision per transaction.
// ----------------------------------------------------------------------------
module lzfd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [lzfd_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                       accept,
    input  logic [7:0]                 in_byte,
    input  logic                       in_valid,
    input  logic                       in_last,
    output lzfd_pkg::item_t            item
);

    typedef enum logic [3:0] {
        PH_BIT1 = 4'b0001,
        PH_BIT2 = 4'b0010,
        PH_LO   = 4'b0100,
        PH_EXT  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        OP_FLAG,
        OP_LIT,
        OP_SHORT,
        OP_HI,
        OP_LO,
        OP_EXT
    } op_t;

    localparam int AW = lzfd_pkg::WIN_AW;
    localparam int CW = lzfd_pkg::CNT_W;
    localparam int LW = lzfd_pkg::LEN_W;

    logic [CW-1:0]   max_reg;
    logic [AW-1:0]   wp_reg,    wp_next;
    logic [CW-1:0]   prod_reg,  prod_next;
    logic [7:0]      flag_reg,  flag_next;
    logic [3:0]      left_reg,  left_next;
    phase_t          phase_reg, phase_next;
    logic [7:0]      pend_reg,  pend_next;
    logic [AW-1:0]   dist_reg,  dist_next;
    logic [LW-1:0]   rem_reg,   rem_next;
    logic            ended_reg, ended_next;
    logic            done_reg,  done_next;
    lzfd_pkg::err_t  err_reg,   err_next;

    logic [7:0]      f;
    logic [3:0]      n;
    phase_t          ph;
    op_t             op;
    logic            sc_en;
    logic [AW-1:0]   sc_dlow;
    logic [LW-1:0]   sc_len;
    logic [AW:0]     sc_dist;
    logic [AW-1:0]   lo_dlow;

    always_comb begin
        wp_next    = wp_reg;
        prod_next  = prod_reg;
        flag_next  = flag_reg;
        left_next  = left_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        dist_next  = dist_reg;
        rem_next   = rem_reg;
        ended_next = ended_reg;
        done_next  = done_reg;
        err_next   = err_reg;

        f       = flag_reg;
        n       = left_reg;
        ph      = phase_reg;
        op      = OP_FLAG;
        sc_en   = 1'b0;
        sc_dlow = '0;
        sc_len  = '0;
        sc_dist = '0;
        lo_dlow = AW'(0) - {pend_reg[3:0], in_byte};

        item       = '0;
        item.waddr = wp_reg;
        item.raddr = wp_reg - dist_reg;

        if (!done_reg) begin
            if (rem_reg != '0) begin
                if (prod_reg >= max_reg) begin
                    err_next  = lzfd_pkg::ERR_TRUNC;
                    done_next = 1'b1;
                    rem_next  = '0;
                end else begin
                    item.ov   = 1'b1;
                    item.copy = 1'b1;
                    wp_next   = wp_reg + AW'(1);
                    prod_next = prod_reg + CW'(1);
                    rem_next  = rem_reg - LW'(1);
                end
            end else if (in_valid && !ended_reg) begin
                item.taken = 1'b1;
                if (in_last) begin
                    ended_next = 1'b1;
                end

                unique case (phase_reg)
                    PH_BIT1: begin
                        if (n == 4'd0) begin
                            op = OP_FLAG;
                        end else if (f[0]) begin
                            f  = f >> 1;
                            n  = n - 4'd1;
                            op = OP_LIT;
                        end else begin
                            f  = f >> 1;
                            n  = n - 4'd1;
                            ph = PH_BIT2;
                            if (n == 4'd0) begin
                                op = OP_FLAG;
                            end else begin
                                op = f[0] ? OP_SHORT : OP_HI;
                                f  = f >> 1;
                                n  = n - 4'd1;
                            end
                        end
                    end
                    PH_BIT2: begin
                        if (n == 4'd0) begin
                            op = OP_FLAG;
                        end else begin
                            op = f[0] ? OP_SHORT : OP_HI;
                            f  = f >> 1;
                            n  = n - 4'd1;
                        end
                    end
                    PH_LO:   op = OP_LO;
                    PH_EXT:  op = OP_EXT;
                    default: op = OP_FLAG;
                endcase

                flag_next = f;
                left_next = n;

                unique case (op)
                    OP_FLAG: begin
                        flag_next  = in_byte;
                        left_next  = 4'd8;
                        phase_next = ph;
                    end
                    OP_LIT: begin
                        phase_next = PH_BIT1;
                        if (prod_reg >= max_reg) begin
                            err_next  = lzfd_pkg::ERR_TRUNC;
                            done_next = 1'b1;
                            rem_next  = '0;
                        end else begin
                            item.ov   = 1'b1;
                            item.lit  = in_byte;
                            wp_next   = wp_reg + AW'(1);
                            prod_next = prod_reg + CW'(1);
                        end
                    end
                    OP_SHORT: begin
                        phase_next = PH_BIT1;
                        sc_en      = 1'b1;
                        sc_dlow    = AW'(7'd64 - {1'b0, in_byte[5:0]});
                        sc_len     = LW'(in_byte[7:6]) + LW'(2);
                    end
                    OP_HI: begin
                        pend_next  = in_byte;
                        phase_next = PH_LO;
                    end
                    OP_LO: begin
                        if (pend_reg[7:4] == 4'd0) begin
                            dist_next  = lo_dlow;
                            phase_next = PH_EXT;
                        end else begin
                            phase_next = PH_BIT1;
                            sc_en      = 1'b1;
                            sc_dlow    = lo_dlow;
                            sc_len     = LW'(pend_reg[7:4]) + LW'(2);
                        end
                    end
                    OP_EXT: begin
                        phase_next = PH_BIT1;
                        if (in_byte == 8'd0) begin
                            err_next  = lzfd_pkg::ERR_ZERO_EXT;
                            done_next = 1'b1;
                            rem_next  = '0;
                        end else begin
                            sc_en   = 1'b1;
                            sc_dlow = dist_reg;
                            sc_len  = LW'(in_byte) + LW'(2);
                        end
                    end
                    default: phase_next = PH_BIT1;
                endcase

                // distance zero encodes a full window
                sc_dist = (sc_dlow == '0) ? (AW+1)'(lzfd_pkg::WIN_DEPTH) : {1'b0, sc_dlow};
                if (sc_en) begin
                    if (CW'(sc_dist) > prod_reg) begin
                        err_next  = lzfd_pkg::ERR_DIST;
                        done_next = 1'b1;
                        rem_next  = '0;
                    end else begin
                        dist_next = sc_dlow;
                        rem_next  = sc_len;
                    end
                end
            end

            if (!done_next && ended_next && rem_next == '0) begin
                done_next = 1'b1;
            end
        end

        item.done = done_next;
        item.err  = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= lzfd_pkg::MAX_OUT_RESET;
            wp_reg    <= '0;
            prod_reg  <= '0;
            flag_reg  <= '0;
            left_reg  <= '0;
            phase_reg <= PH_BIT1;
            pend_reg  <= '0;
            dist_reg  <= '0;
            rem_reg   <= '0;
            ended_reg <= 1'b0;
            done_reg  <= 1'b0;
            err_reg   <= lzfd_pkg::ERR_NONE;
        end else begin
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
            if (accept) begin
                wp_reg    <= wp_next;
                prod_reg  <= prod_next;
                flag_reg  <= flag_next;
                left_reg  <= left_next;
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                dist_reg  <= dist_next;
                rem_reg   <= rem_next;
                ended_reg <= ended_next;
                done_reg  <= done_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

FILE: rtl/lz_flag_bit_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lz_flag_bit_decompressor_unit
// LZ decompressor with flag-bit token stream and a 4096-byte history window.
//
// Every s_ transaction is one tick: s_tuser[0] says whether s_tdata holds an
// offered compressed byte and s_tlast marks the final one. Every tick yields
// exactly one m_ transaction carrying the emitted byte (m_tdata, zero when
// none) and the flags out_valid, byte_taken, done_res and error_code.
// While a copy runs, offered bytes are not taken (byte_taken low) and the
// tick emits one byte from the history window instead.
// Each s_ transaction's result is registered in the output stage and leaves as
// its m_ transaction; the block takes one tick per cycle unless m_tready stalls
// the output stage. Copy reads go through the window RAM's registered port; a read
// of the byte written by the previous tick is forwarded from the output stage.
// cfg_we loads the output byte limit; write it only while idle.
// Reset (aresetn low, synchronous) clears the parser state, the limit to
// 262144 and the output stage's valid flag; the window RAM is not cleared.
// When m_tready is low while the output register is full, it holds and s_tready drops.
// ----------------------------------------------------------------------------
module lz_flag_bit_decompressor_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [lzfd_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // in_byte
    input  logic [0:0]                 s_tuser,   // in_valid
    input  logic                       s_tlast,   // in_last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // out_byte
    output logic [4:0]                 m_tuser    // out_valid, byte_taken, done_res,
                                                  // error_code[1:0]
);

    lzfd_pkg::item_t item;
    lzfd_pkg::item_t st2_reg;
    logic            st2_valid_reg;
    logic            fwd_reg;
    logic [7:0]      fwd_data_reg;
    logic [7:0]      rd_data;
    logic [7:0]      st2_byte;
    logic            accept;
    logic            m_fire;
    logic            hit;

    assign s_tready = !st2_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_fire   = st2_valid_reg && m_tready;

    lzfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_tdata),
        .in_valid  (s_tuser[0]),
        .in_last   (s_tlast),
        .item      (item)
    );

    assign st2_byte = st2_reg.copy ? (fwd_reg ? fwd_data_reg : rd_data) : st2_reg.lit;
    assign hit      = st2_valid_reg && st2_reg.ov && (st2_reg.waddr == item.raddr);

    lzfd_hist_ram u_hist (
        .aclk  (aclk),
        .re    (accept),
        .raddr (item.raddr),
        .rdata (rd_data),
        .we    (m_fire && st2_reg.ov),
        .waddr (st2_reg.waddr),
        .wdata (st2_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (accept) begin
            st2_valid_reg <= 1'b1;
        end else if (m_fire) begin
            st2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st2_reg <= item;
            fwd_reg <= hit;
        end
        if (m_fire) begin
            fwd_data_reg <= st2_byte;
        end
    end

    assign m_tvalid = st2_valid_reg;
    assign m_tdata  = st2_reg.ov ? st2_byte : 8'd0;
    assign m_tuser  = {st2_reg.err, st2_reg.done, st2_reg.taken, st2_reg.ov};

endmodule
